// File: rtl/core/positional_list_engine_top_defines.svh
// Assertion macros used by the checker file of the list engine.
// Each macro places one labeled concurrent assertion, sampled on the rising edge
// of the given clock and switched off while the given active-low reset is low.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLIST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLIST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/plist_pkg.sv
`default_nettype none

package plist_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned CMD_W        = 4;
	localparam int unsigned POS_W        = 7;
	localparam int unsigned CNT_OUT_W    = 7;
	localparam int unsigned ST_W         = 2;
	localparam int unsigned CAPACITY_DEF = 64;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 4'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 4'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AT   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_RD_HEAD  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_RD_TAIL  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RD_AT    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_RM_HEAD  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_RM_TAIL  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_RM_AT    = 4'd8;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd9;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	// Operations broadcast to the cells.
	localparam int unsigned OP_W = 3;
	localparam logic [OP_W-1:0] OP_HOLD = 3'd0;
	localparam logic [OP_W-1:0] OP_NOP  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS  = 3'd2;
	localparam logic [OP_W-1:0] OP_REM  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [ST_W-1:0]          status;
		logic [CNT_OUT_W-1:0]     count;
	} rsp_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/plist_cell.sv
`default_nettype none

module plist_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CMP_W = 7
) (
	input  logic                                clk,
	input  plist_pkg::cell_ctl_t                ctl,
	input  logic [CMP_W-1:0]                    pos,
	input  logic signed [plist_pkg::DATA_W-1:0] left,
	input  logic signed [plist_pkg::DATA_W-1:0] right,
	output logic signed [plist_pkg::DATA_W-1:0] data,
	output logic signed [plist_pkg::DATA_W-1:0] rd
);
	import plist_pkg::*;

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] rd_q;

	// On insert, cells behind the position take their left neighbor; on remove,
	// cells at or behind it take their right neighbor.
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (MY_IDX > pos) begin
					data_q <= left;
				end else if (MY_IDX == pos) begin
					data_q <= ctl.value;
				end
			end
			OP_REM: begin
				if (MY_IDX >= pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	// The read tap shows the entry only in the selected cell, zero elsewhere.
	always_ff @(posedge clk) begin
		if (ctl.op != OP_HOLD) begin
			rd_q <= (ctl.op == OP_READ && MY_IDX == pos) ? data_q : '0;
		end
	end

	assign data = data_q;
	assign rd   = rd_q;

endmodule

`default_nettype wire

// File: rtl/core/plist_rdmux.sv
`default_nettype none

module plist_rdmux #(
	parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input  logic signed [plist_pkg::DATA_W-1:0] taps [CAPACITY],
	output logic signed [plist_pkg::DATA_W-1:0] value
);
	import plist_pkg::*;

	// At most one tap is nonzero, so an OR of all taps picks the read entry.
	always_comb begin
		value = '0;
		for (int unsigned i = 0; i < CAPACITY; i++) begin
			value = value | taps[i];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/positional_list_engine_top.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | req  (cmd, value, position)
// rsp     | out       | rsp_valid, rsp_stall | rsp  (read_value, status, count)
//
// A command is not taken while the one before it waits in the second stage:
// the cell row shifts or selects in the cycle of the transfer, registering the
// read taps, and the read OR tree then loads the result register from them.
// Reset clears the entry count and handshake state, not the entries themselves.
// While rsp_stall holds a result, one further command is taken and waits in the
// second stage; req_stall rises until that stage drains.
`default_nettype none

module positional_list_engine_top #(
	parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  plist_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output plist_pkg::rsp_t rsp
);
	import plist_pkg::*;

	// Count width holds CAPACITY itself; compare width covers both the count and
	// the widest position a command can carry.
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int unsigned CEXT_W = CNT_W + CNT_OUT_W;

	logic             accept;
	logic             move;
	logic [CNT_W-1:0] count_q;

	// Second stage: status and count of the command whose read taps are pending.
	logic             pend_q;
	logic [ST_W-1:0]  status_s2;
	logic [CNT_W-1:0] count_s2;

	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// Decoded command.
	logic [CMP_W-1:0] n_ext;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] tail_pos;
	logic [CMP_W-1:0] op_pos;
	logic [OP_W-1:0]  dec_op;
	logic [ST_W-1:0]  dec_status;
	logic [CNT_W-1:0] dec_count;
	logic             is_empty;
	logic             is_full;

	cell_ctl_t           ctl;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
	logic signed [DATA_W-1:0] rd_value;
	logic [CEXT_W-1:0]        count_ext;

	assign req_stall = pend_q;
	assign accept    = req_valid & ~pend_q;
	assign move      = pend_q & (~rsp_valid_q | ~rsp_stall);

	assign n_ext    = CMP_W'(count_q);
	assign pos_ext  = CMP_W'(req.position);
	assign tail_pos = CMP_W'(n_ext - CMP_W'(1));
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		dec_op     = OP_NOP;
		dec_status = ST_OK;
		dec_count  = count_q;
		op_pos     = '0;
		case (req.cmd)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				if (req.cmd == CMD_INS_TAIL) begin
					op_pos = n_ext;
				end else if (req.cmd == CMD_INS_AT) begin
					op_pos = pos_ext;
				end
				// A bad position is reported ahead of a full list.
				if (op_pos > n_ext) begin
					dec_status = ST_INVALID;
				end else if (is_full) begin
					dec_status = ST_FULL;
				end else begin
					dec_op    = OP_INS;
					dec_count = CNT_W'(count_q + CNT_W'(1));
				end
			end
			CMD_RD_HEAD, CMD_RD_TAIL: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_op = OP_READ;
					op_pos = (req.cmd == CMD_RD_TAIL) ? tail_pos : '0;
				end
			end
			CMD_RD_AT: begin
				if (pos_ext >= n_ext) begin
					dec_status = ST_INVALID;
				end else begin
					dec_op = OP_READ;
					op_pos = pos_ext;
				end
			end
			CMD_RM_HEAD, CMD_RM_TAIL: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_op    = OP_REM;
					op_pos    = (req.cmd == CMD_RM_TAIL) ? tail_pos : '0;
					dec_count = CNT_W'(count_q - CNT_W'(1));
				end
			end
			CMD_RM_AT: begin
				if (pos_ext >= n_ext) begin
					dec_status = ST_INVALID;
				end else begin
					dec_op    = OP_REM;
					op_pos    = pos_ext;
					dec_count = CNT_W'(count_q - CNT_W'(1));
				end
			end
			CMD_CLEAR: begin
				dec_count = '0;
			end
			default: begin
			end
		endcase
	end

	// The row of cells only moves on a transfer; otherwise every cell holds,
	// including its read tap, which the second stage is still consuming.
	assign ctl.op    = accept ? dec_op : OP_HOLD;
	assign ctl.value = req.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		plist_cell #(
			.IDX   (i),
			.CMP_W (CMP_W)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (op_pos),
			.left  (left_d),
			.right (right_d),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	plist_rdmux #(
		.CAPACITY (CAPACITY)
	) u_rdmux (
		.taps  (cell_rd),
		.value (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= dec_count;
				pend_q  <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s2 <= dec_status;
			count_s2  <= dec_count;
		end
	end

	assign count_ext = CEXT_W'(count_s2);

	always_ff @(posedge clk) begin
		if (move) begin
			rsp_q.read_value <= rd_value;
			rsp_q.status     <= status_s2;
			rsp_q.count      <= count_ext[CNT_OUT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: rtl/core/plist_chk.sv
`default_nettype none

`include "positional_list_engine_top_defines.svh"

module plist_chk #(
	parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input plist_pkg::rsp_t rsp
);
	import plist_pkg::*;

	localparam logic [CNT_OUT_W-1:0] CAP_OUT = CNT_OUT_W'(CAPACITY);

	// A held result stays put until it is taken.
	`PLIST_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

	// A fresh result always has a command transfer behind it, registered through the read taps and the result register.
	`PLIST_ASSERT_SAME(a_rsp_cause, clk, arst_n, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a command transfer")

	// An empty report always comes with a zero count.
	`PLIST_ASSERT_SAME(a_empty_cnt, clk, arst_n, rsp_valid && rsp.status == ST_EMPTY, rsp.count == '0, "empty status with nonzero count")

	// A full report always comes with the count at capacity.
	`PLIST_ASSERT_SAME(a_full_cnt, clk, arst_n, rsp_valid && rsp.status == ST_FULL, rsp.count == CAP_OUT, "full status below capacity")

	// Only a successful read carries a nonzero value.
	`PLIST_ASSERT_SAME(a_rd_ok, clk, arst_n, rsp_valid && rsp.read_value != '0, rsp.status == ST_OK, "read value on a failed command")

endmodule

bind positional_list_engine_top plist_chk #(
	.CAPACITY (CAPACITY)
) u_plist_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

// File: test/plist_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the list engine, keeps its own copy of the list and
// compares every result transfer with the oldest predicted result.
module plist_result_checker #(
	parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  plist_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  plist_pkg::rsp_t rsp,
	output int unsigned     errors,
	output int unsigned     pending
);

	import plist_pkg::*;

	logic signed [DATA_W-1:0] list_mem [CAPACITY];
	int unsigned              list_len;
	rsp_t                     queued_results [$];
	rsp_t                     oldest;
	int unsigned              mismatch_count = 0;

	assign errors = mismatch_count;

	task automatic flag_error(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Applies one command to the shadow list and returns the result it must give.
	function automatic rsp_t apply_list_cmd(req_t r);
		rsp_t        res;
		int unsigned n;
		int unsigned slot;
		res = '0;
		res.status = ST_OK;
		n = list_len;
		case (r.cmd)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				slot = (r.cmd == CMD_INS_HEAD) ? 0 : (r.cmd == CMD_INS_TAIL) ? n : r.position;
				if (slot > n)
					res.status = ST_INVALID;
				else if (n >= CAPACITY)
					res.status = ST_FULL;
				else begin
					for (int i = n; i > slot; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[slot] = r.value;
					list_len++;
				end
			end
			CMD_RD_HEAD, CMD_RD_TAIL: begin
				if (n == 0)
					res.status = ST_EMPTY;
				else
					res.read_value = list_mem[(r.cmd == CMD_RD_HEAD) ? 0 : n - 1];
			end
			CMD_RD_AT: begin
				if (r.position >= n)
					res.status = ST_INVALID;
				else
					res.read_value = list_mem[r.position];
			end
			CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_AT: begin
				slot = (r.cmd == CMD_RM_HEAD) ? 0 : (r.cmd == CMD_RM_TAIL) ? n - 1 : r.position;
				if (n == 0 && r.cmd != CMD_RM_AT)
					res.status = ST_EMPTY;
				else if (r.position >= n && r.cmd == CMD_RM_AT)
					res.status = ST_INVALID;
				else begin
					for (int i = slot; i + 1 < n; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			CMD_CLEAR: list_len = 0;
			default: ;
		endcase
		res.count = list_len[CNT_OUT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			queued_results.delete();
			pending <= 0;
		end else begin
			if (req_valid && !req_stall)
				queued_results.push_back(apply_list_cmd(req));
			if (rsp_valid && !rsp_stall) begin
				if (queued_results.size() == 0)
					flag_error($sformatf("result with nothing expected: %p", rsp));
				else begin
					oldest = queued_results.pop_front();
					if (rsp.read_value !== oldest.read_value)
						flag_error($sformatf("read_value %0d, expected %0d",
							rsp.read_value, oldest.read_value));
					if (rsp.status !== oldest.status)
						flag_error($sformatf("status %0d, expected %0d",
							rsp.status, oldest.status));
					if (rsp.count !== oldest.count)
						flag_error($sformatf("count %0d, expected %0d",
							rsp.count, oldest.count));
				end
			end
			pending <= queued_results.size();
		end
	end

endmodule

// File: test/tb_positional_list_engine_top.sv
`timescale 1ns / 100ps

// Stimulus side of the list engine test. The checker beside the block predicts and
// compares; this module only produces commands, stalls the result channel and
// decides the verdict.
module tb_positional_list_engine_top;

	import plist_pkg::*;

	// The block takes no further command codes above clear; these are the unused ones.
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_CLEAR + 1'b1;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = {CMD_W{1'b1}};

	// Cycles in a row without any transfer before the run is declared hung.
	localparam int unsigned HANG_LIMIT = 2000;

	// Items of random stimulus in each of the three phases.
	localparam int unsigned RANDOM_PER_PHASE = 360;

	typedef enum logic [1:0] {MODE_FILL, MODE_MIX, MODE_DRAIN} list_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	int unsigned errors;
	int unsigned pending;

	// Percentages of cycles in which the sender holds back or the receiver stalls.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_cycles = 0;

	positional_list_engine_top #(
		.CAPACITY (CAPACITY_DEF)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	plist_result_checker #(
		.CAPACITY (CAPACITY_DEF)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// The receiver decides afresh every cycle whether to stall the result channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// The watchdog restarts whenever either channel completes a transfer. If the
	// block stops moving for too long, the run ends as a failure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one command and returns at the clock edge where its transfer happens.
	// A random number of idle cycles may come first. The valid is only lowered
	// when a gap is taken, so back-to-back commands keep it high without a glitch.
	task automatic send_cmd(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v,
			logic [POS_W-1:0] p);
		req_t item;
		item.cmd = c;
		item.value = v;
		item.position = p;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Chooses a command with a bias that depends on whether the list is meant to
	// grow, shrink or wander around its current size.
	function automatic logic [CMD_W-1:0] pick_cmd(list_mode_e mode);
		int unsigned roll;
		int unsigned ins_pct;
		int unsigned rd_pct;
		int unsigned rm_pct;
		logic [CMD_W-1:0] ins_ops [3] = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT};
		logic [CMD_W-1:0] rd_ops [3] = '{CMD_RD_HEAD, CMD_RD_TAIL, CMD_RD_AT};
		logic [CMD_W-1:0] rm_ops [3] = '{CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_AT};
		case (mode)
			MODE_FILL: begin
				ins_pct = 85; rd_pct = 94; rm_pct = 99;
			end
			MODE_DRAIN: begin
				ins_pct = 20; rd_pct = 40; rm_pct = 98;
			end
			default: begin
				ins_pct = 38; rd_pct = 70; rm_pct = 97;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			return ins_ops[$urandom_range(0, 2)];
		if (roll < rd_pct)
			return rd_ops[$urandom_range(0, 2)];
		if (roll < rm_pct)
			return rm_ops[$urandom_range(0, 2)];
		// What is left is split between clearing the list and unused codes. A
		// clear while filling would undo the climb toward a full list.
		if (mode != MODE_FILL && $urandom_range(0, 1) == 0)
			return CMD_CLEAR;
		return $urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI);
	endfunction

	// Random commands in segments. Each segment fills, mixes or drains the list,
	// so the list regularly reaches both the empty and the full state.
	task automatic run_random(int unsigned n_items);
		list_mode_e               mode;
		int unsigned              seg_left;
		logic [CMD_W-1:0]         c;
		logic [POS_W-1:0]         p;
		logic signed [DATA_W-1:0] v;
		mode = MODE_DRAIN;
		seg_left = 0;
		for (int unsigned k = 0; k < n_items; k++) begin
			if (seg_left == 0) begin
				case (mode)
					MODE_FILL:  mode = MODE_MIX;
					MODE_MIX:   mode = MODE_DRAIN;
					default:    mode = MODE_FILL;
				endcase
				seg_left = (mode == MODE_FILL) ? $urandom_range(70, 120)
					: $urandom_range(30, 80);
			end
			seg_left--;
			c = pick_cmd(mode);
			// Positions mostly fall near the live part of the list, where the
			// boundary between valid and invalid positions moves with the count.
			if ($urandom_range(0, 99) < 85)
				p = $urandom_range(0, CAPACITY_DEF + 2);
			else
				p = $urandom;
			if ($urandom_range(0, 99) < 10) begin
				case ($urandom_range(0, 3))
					0:       v = {1'b1, {(DATA_W-1){1'b0}}};
					1:       v = {1'b0, {(DATA_W-1){1'b1}}};
					2:       v = '0;
					default: v = '1;
				endcase
			end else begin
				v = $urandom;
			end
			send_cmd(c, v, p);
		end
	endtask

	int unsigned send_idle_by_phase [3] = '{7, 80, 0};
	int unsigned stall_by_phase [3] = '{80, 7, 0};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct <= send_idle_by_phase[0];
		stall_pct <= stall_by_phase[0];
		@(posedge clk);

		// Directed commands. The list starts empty, so the first ones exercise the
		// empty and out-of-range answers before anything is stored.
		send_cmd(CMD_RD_HEAD, 32'sd5, '0);
		send_cmd(CMD_RM_TAIL, 32'sd0, '0);
		send_cmd(CMD_RD_AT, 32'sd0, 7'd0);
		send_cmd(CMD_INS_AT, 32'sd9, 7'd1);
		// Build a short list holding both extremes of the value range.
		send_cmd(CMD_INS_TAIL, 32'sh7FFF_FFFF, '0);
		send_cmd(CMD_INS_HEAD, 32'sh8000_0000, '0);
		send_cmd(CMD_INS_AT, -32'sd1, 7'd1);
		// Inserting at a position equal to the count appends at the tail.
		send_cmd(CMD_INS_AT, 32'sd0, 7'd3);
		send_cmd(CMD_RD_HEAD, '0, '0);
		send_cmd(CMD_RD_TAIL, '0, '0);
		send_cmd(CMD_RD_AT, '0, 7'd2);
		send_cmd(CMD_RD_AT, '0, 7'd127);
		send_cmd(CMD_INS_AT, 32'sd3, 7'd127);
		send_cmd(CMD_RM_AT, '0, 7'd4);
		send_cmd(CMD_RM_AT, '0, 7'd1);
		send_cmd(CMD_RM_HEAD, '0, '0);
		send_cmd(CMD_RM_TAIL, '0, '0);
		send_cmd(CMD_RD_TAIL, '0, '0);
		send_cmd(CMD_CLEAR, '0, '0);
		// After the clear the list must behave as empty again.
		send_cmd(CMD_RM_HEAD, '0, '0);
		send_cmd(CMD_RD_TAIL, '0, '0);
		send_cmd(CMD_RM_AT, '0, 7'd0);
		send_cmd(CMD_UNUSED_LO, 32'sd77, 7'd3);
		send_cmd(CMD_UNUSED_HI, -32'sd77, 7'd127);

		// Three phases: a slow receiver, then a slow sender, then full speed.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct <= send_idle_by_phase[ph];
			stall_pct <= stall_by_phase[ph];
			run_random(RANDOM_PER_PHASE);
		end
		req_valid <= 1'b0;

		// Wait for every predicted result, and keep clocking before the verdict so that a stray
		// extra result would still be caught by the checker.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/plist_pkg.sv
rtl/core/plist_cell.sv
rtl/core/plist_rdmux.sv
rtl/core/positional_list_engine_top.sv
rtl/core/plist_chk.sv
test/plist_result_checker.sv
test/tb_positional_list_engine_top.sv
